>>> src/bce_pkg.sv
package bce_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int MV_W       = 13;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV    = 2'd2;

  localparam logic [MV_W-1:0] FULL_MV_RST  = 13'd4200;
  localparam logic [MV_W-1:0] EMPTY_MV_RST = 13'd3000;

  // raw code to battery mV: 3300 mV full scale, doubled by the divider
  localparam int RAW_PROD_W = 25;
  localparam logic [RAW_PROD_W-1:0] RAW_SCALE = 25'd6600;
  localparam logic [RAW_PROD_W-1:0] RAW_ROUND = 25'd2048;
  localparam int RAW_SHIFT = 12;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;

  localparam int CURVE_POINTS = 21;
  localparam int SEG_W        = $clog2(CURVE_POINTS);
  localparam int PROD_W       = 16;
  localparam int PCT_NUM_W    = 16;
  localparam int PCT_DEN_W    = 10;

  localparam int DEFAULT_RING_DEPTH = 5;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_STORE,
    OP_SUM,
    OP_AVG_INIT,
    OP_DIV,
    OP_AVG_DONE,
    OP_CHECK,
    OP_SEARCH,
    OP_MUL1,
    OP_MUL2,
    OP_NUM,
    OP_PCT_DONE,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_OUT_BLOCKED,
    C_RING_MORE,
    C_CNT_ZERO,
    C_DIV_BUSY,
    C_DECIDED,
    C_SEG_MORE,
    C_NOT_FOUND
  } cond_e;

  typedef enum logic [3:0] {
    S_FETCH,
    S_STORE,
    S_SUM,
    S_AVG_INIT,
    S_AVG_DIV,
    S_AVG_DONE,
    S_CHECK,
    S_SEARCH,
    S_FOUND,
    S_MUL1,
    S_MUL2,
    S_NUM,
    S_PCT_DIV,
    S_PCT_DONE,
    S_EMIT,
    S_WRAP
  } step_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e target;
    logic  hold;   // op runs only when the jump is not taken
  } ucode_t;

  typedef struct packed {
    op_e  op;
    logic go;
  } bce_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_blocked;
    logic ring_more;
    logic cnt_zero;
    logic div_busy;
    logic decided;
    logic seg_more;
    logic not_found;
  } bce_flags_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                read_ok;
  } in_item_t;

  function automatic ucode_t ucode(input step_e s);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_NEVER, target: S_FETCH, hold: 1'b0};
    unique case (s)
      S_FETCH:    w = '{op: OP_LOAD,     cond: C_NO_IN,       target: S_FETCH,   hold: 1'b1};
      S_STORE:    w = '{op: OP_STORE,    cond: C_NEVER,       target: S_FETCH,   hold: 1'b0};
      S_SUM:      w = '{op: OP_SUM,      cond: C_RING_MORE,   target: S_SUM,     hold: 1'b0};
      S_AVG_INIT: w = '{op: OP_AVG_INIT, cond: C_CNT_ZERO,    target: S_EMIT,    hold: 1'b0};
      S_AVG_DIV:  w = '{op: OP_DIV,      cond: C_DIV_BUSY,    target: S_AVG_DIV, hold: 1'b0};
      S_AVG_DONE: w = '{op: OP_AVG_DONE, cond: C_NEVER,       target: S_FETCH,   hold: 1'b0};
      S_CHECK:    w = '{op: OP_CHECK,    cond: C_DECIDED,     target: S_EMIT,    hold: 1'b0};
      S_SEARCH:   w = '{op: OP_SEARCH,   cond: C_SEG_MORE,    target: S_SEARCH,  hold: 1'b0};
      S_FOUND:    w = '{op: OP_NOP,      cond: C_NOT_FOUND,   target: S_EMIT,    hold: 1'b0};
      S_MUL1:     w = '{op: OP_MUL1,     cond: C_NEVER,       target: S_FETCH,   hold: 1'b0};
      S_MUL2:     w = '{op: OP_MUL2,     cond: C_NEVER,       target: S_FETCH,   hold: 1'b0};
      S_NUM:      w = '{op: OP_NUM,      cond: C_NEVER,       target: S_FETCH,   hold: 1'b0};
      S_PCT_DIV:  w = '{op: OP_DIV,      cond: C_DIV_BUSY,    target: S_PCT_DIV, hold: 1'b0};
      S_PCT_DONE: w = '{op: OP_PCT_DONE, cond: C_NEVER,       target: S_FETCH,   hold: 1'b0};
      S_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_BLOCKED, target: S_EMIT,    hold: 1'b1};
      S_WRAP:     w = '{op: OP_NOP,      cond: C_ALWAYS,      target: S_FETCH,   hold: 1'b0};
    endcase
    return w;
  endfunction

  // discharge curve, falling voltage
  function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] i);
    logic [MV_W-1:0] r;
    unique case (i)
      5'd0:  r = 13'd4200;
      5'd1:  r = 13'd4150;
      5'd2:  r = 13'd4110;
      5'd3:  r = 13'd4080;
      5'd4:  r = 13'd4020;
      5'd5:  r = 13'd3980;
      5'd6:  r = 13'd3950;
      5'd7:  r = 13'd3910;
      5'd8:  r = 13'd3870;
      5'd9:  r = 13'd3850;
      5'd10: r = 13'd3840;
      5'd11: r = 13'd3820;
      5'd12: r = 13'd3800;
      5'd13: r = 13'd3790;
      5'd14: r = 13'd3770;
      5'd15: r = 13'd3750;
      5'd16: r = 13'd3730;
      5'd17: r = 13'd3710;
      5'd18: r = 13'd3690;
      5'd19: r = 13'd3610;
      5'd20: r = 13'd3270;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_W-1:0] i);
    logic [PCT_W-1:0] r;
    unique case (i)
      5'd0:  r = 7'd100;
      5'd1:  r = 7'd95;
      5'd2:  r = 7'd90;
      5'd3:  r = 7'd85;
      5'd4:  r = 7'd80;
      5'd5:  r = 7'd75;
      5'd6:  r = 7'd70;
      5'd7:  r = 7'd65;
      5'd8:  r = 7'd60;
      5'd9:  r = 7'd55;
      5'd10: r = 7'd50;
      5'd11: r = 7'd45;
      5'd12: r = 7'd40;
      5'd13: r = 7'd35;
      5'd14: r = 7'd30;
      5'd15: r = 7'd25;
      5'd16: r = 7'd20;
      5'd17: r = 7'd15;
      5'd18: r = 7'd10;
      5'd19: r = 7'd5;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/bce_if.sv
interface bce_in_if;
  logic                          valid;
  logic                          ready;
  logic [bce_pkg::SAMPLE_W-1:0]  sample;
  logic                          read_ok;

  modport source (output valid, output sample, output read_ok, input ready);
  modport sink (input valid, input sample, input read_ok, output ready);
endinterface

interface bce_out_if;
  logic                       valid;
  logic                       ready;
  logic [bce_pkg::MV_W-1:0]   battery_mv;
  logic [bce_pkg::PCT_W-1:0]  percent;

  modport source (output valid, output battery_mv, output percent, input ready);
  modport sink (input valid, input battery_mv, input percent, output ready);
endinterface

>>> src/bce_seq.sv
module bce_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bce_pkg::bce_flags_t flags_i,
  output bce_pkg::bce_ctrl_t  ctrl_o
);

  bce_pkg::step_e  pc_q, pc_d;
  bce_pkg::ucode_t cw;
  logic            take;

  always_comb begin
    cw = bce_pkg::ucode(pc_q);
    unique case (cw.cond)
      bce_pkg::C_NEVER:       take = 1'b0;
      bce_pkg::C_ALWAYS:      take = 1'b1;
      bce_pkg::C_NO_IN:       take = !flags_i.in_valid;
      bce_pkg::C_OUT_BLOCKED: take = flags_i.out_blocked;
      bce_pkg::C_RING_MORE:   take = flags_i.ring_more;
      bce_pkg::C_CNT_ZERO:    take = flags_i.cnt_zero;
      bce_pkg::C_DIV_BUSY:    take = flags_i.div_busy;
      bce_pkg::C_DECIDED:     take = flags_i.decided;
      bce_pkg::C_SEG_MORE:    take = flags_i.seg_more;
      bce_pkg::C_NOT_FOUND:   take = flags_i.not_found;
      default:                take = 1'b0;
    endcase
    ctrl_o.op = cw.op;
    ctrl_o.go = !(cw.hold && take);
    pc_d = take ? cw.target : bce_pkg::step_e'(pc_q + 4'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= bce_pkg::S_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> src/bce_dp.sv
module bce_dp #(
  parameter int RING_DEPTH = bce_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bce_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bce_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  bce_pkg::bce_ctrl_t              ctrl_i,
  output bce_pkg::bce_flags_t             flags_o,
  bce_in_if.sink                          in_if,
  bce_out_if.source                       out_if
);

  localparam int MV_W   = bce_pkg::MV_W;
  localparam int PCT_W  = bce_pkg::PCT_W;
  localparam int SEG_W  = bce_pkg::SEG_W;
  localparam int PROD_W = bce_pkg::PROD_W;
  localparam int RIDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = MV_W + $clog2(RING_DEPTH);
  localparam int DIV_W  = (SUM_W > bce_pkg::PCT_NUM_W) ? SUM_W : bce_pkg::PCT_NUM_W;
  localparam int DEN_W  = (CNT_W > bce_pkg::PCT_DEN_W) ? CNT_W : bce_pkg::PCT_DEN_W;
  localparam int BITS_W = $clog2(DIV_W + 1);
  localparam logic [RIDX_W-1:0] RIDX_LAST = RIDX_W'(RING_DEPTH - 1);
  localparam logic [SEG_W-1:0]  SEG_LAST  = SEG_W'(bce_pkg::CURVE_POINTS - 2);

  logic                 kind_q;
  logic [MV_W-1:0]      full_q, empty_q;

  logic [MV_W-1:0]      conv_q;
  logic [MV_W-1:0]      ring_q [RING_DEPTH];
  logic [RIDX_W-1:0]    slot_q, ridx_q;
  logic [SUM_W-1:0]     sum_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [MV_W-1:0]      avg_q;
  logic [PCT_W-1:0]     pct_q;
  logic [SEG_W-1:0]     seg_q;
  logic                 found_q;
  logic [PROD_W-1:0]    prod1_q, prod2_q;
  logic [DIV_W-1:0]     dq_q;
  logic [DEN_W-1:0]     rem_q, den_q;
  logic [BITS_W-1:0]    bits_q;
  logic                 out_valid_q;
  logic [MV_W-1:0]      out_mv_q;
  logic [PCT_W-1:0]     out_pct_q;

  logic                    ex;
  logic [bce_pkg::RAW_PROD_W-1:0] raw_prod;
  logic [MV_W-1:0]         conv_d, clamp_v, ring_rd;
  logic [SEG_W-1:0]        seg_nx;
  logic [MV_W-1:0]         v1, v2, dv, dmv;
  logic [PCT_W-1:0]        p1, dp;
  logic                    hit, at_full, at_empty, above_top;
  logic [DEN_W:0]          trial;
  logic                    ge;
  logic [PROD_W-1:0]       diff;

  assign ex = ctrl_i.go;

  always_comb begin
    raw_prod = bce_pkg::RAW_PROD_W'(in_if.sample) * bce_pkg::RAW_SCALE;
    if (!in_if.read_ok) begin
      conv_d = '0;
    end else if (kind_q) begin
      conv_d = MV_W'((raw_prod + bce_pkg::RAW_ROUND) >> bce_pkg::RAW_SHIFT);
    end else begin
      conv_d = {in_if.sample, 1'b0};
    end
    clamp_v = (conv_q > full_q) ? full_q : conv_q;
    ring_rd = ring_q[ridx_q];

    seg_nx = seg_q + 1'b1;
    v1  = bce_pkg::curve_mv(seg_q);
    v2  = bce_pkg::curve_mv(seg_nx);
    p1  = bce_pkg::curve_pct(seg_q);
    dv  = v1 - v2;
    dp  = p1 - bce_pkg::curve_pct(seg_nx);
    dmv = v1 - avg_q;
    hit = avg_q >= v2;

    at_full   = avg_q >= full_q;
    at_empty  = avg_q <= empty_q;
    above_top = avg_q >= bce_pkg::curve_mv('0);

    // one restoring division step
    trial = {rem_q, dq_q[DIV_W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = prod1_q - prod2_q;
  end

  always_comb begin
    flags_o.in_valid    = in_if.valid;
    flags_o.out_blocked = out_valid_q && !out_if.ready;
    flags_o.ring_more   = ridx_q != RIDX_LAST;
    flags_o.cnt_zero    = cnt_q == '0;
    flags_o.div_busy    = bits_q > BITS_W'(1);
    flags_o.decided     = at_full || at_empty || above_top;
    flags_o.seg_more    = !hit && (seg_q != SEG_LAST);
    flags_o.not_found   = !found_q;
  end

  assign in_if.ready       = ctrl_i.op == bce_pkg::OP_LOAD;
  assign out_if.valid      = out_valid_q;
  assign out_if.battery_mv = out_mv_q;
  assign out_if.percent    = out_pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= 1'b0;
      full_q  <= bce_pkg::FULL_MV_RST;
      empty_q <= bce_pkg::EMPTY_MV_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bce_pkg::CFG_SAMPLE_KIND: kind_q  <= cfg_data_i[0];
        bce_pkg::CFG_FULL_MV:     full_q  <= cfg_data_i;
        bce_pkg::CFG_EMPTY_MV:    empty_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // history ring and its pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      slot_q <= '0;
      ridx_q <= '0;
    end else if (ex) begin
      if (ctrl_i.op == bce_pkg::OP_STORE) begin
        ring_q[slot_q] <= clamp_v;
        slot_q <= (slot_q == RIDX_LAST) ? '0 : slot_q + 1'b1;
        ridx_q <= '0;
      end else if (ctrl_i.op == bce_pkg::OP_SUM) begin
        ridx_q <= (ridx_q == RIDX_LAST) ? '0 : ridx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ex && ctrl_i.op == bce_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ex) begin
      unique case (ctrl_i.op)
        bce_pkg::OP_LOAD: begin
          conv_q <= conv_d;
        end
        bce_pkg::OP_STORE: begin
          sum_q <= '0;
          cnt_q <= '0;
        end
        bce_pkg::OP_SUM: begin
          if (ring_rd != '0) begin
            sum_q <= sum_q + SUM_W'(ring_rd);
            cnt_q <= cnt_q + 1'b1;
          end
        end
        bce_pkg::OP_AVG_INIT: begin
          dq_q   <= DIV_W'(sum_q) + DIV_W'(cnt_q >> 1);
          den_q  <= DEN_W'(cnt_q);
          rem_q  <= '0;
          bits_q <= BITS_W'(DIV_W);
          avg_q  <= '0;
          pct_q  <= bce_pkg::PCT_NONE;
        end
        bce_pkg::OP_DIV: begin
          rem_q  <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
          dq_q   <= {dq_q[DIV_W-2:0], ge};
          bits_q <= bits_q - 1'b1;
        end
        bce_pkg::OP_AVG_DONE: begin
          avg_q   <= dq_q[MV_W-1:0];
          seg_q   <= '0;
          found_q <= 1'b0;
        end
        bce_pkg::OP_CHECK: begin
          pct_q <= (at_full || (!at_empty && above_top)) ? bce_pkg::PCT_FULL
                                                         : bce_pkg::PCT_NONE;
        end
        bce_pkg::OP_SEARCH: begin
          found_q <= hit;
          if (!hit && seg_q != SEG_LAST) begin
            seg_q <= seg_nx;
          end
        end
        bce_pkg::OP_MUL1: begin
          prod1_q <= PROD_W'(p1 * dv);
        end
        bce_pkg::OP_MUL2: begin
          prod2_q <= PROD_W'(dmv * dp);
        end
        bce_pkg::OP_NUM: begin
          // (2*(p1*dv - d*dp) + dv) / (2*dv), rounds half up
          dq_q   <= DIV_W'({diff, 1'b0}) + DIV_W'(dv);
          den_q  <= DEN_W'({dv, 1'b0});
          rem_q  <= '0;
          bits_q <= BITS_W'(DIV_W);
        end
        bce_pkg::OP_PCT_DONE: begin
          pct_q <= (dq_q > DIV_W'(bce_pkg::PCT_FULL)) ? bce_pkg::PCT_FULL
                                                      : dq_q[PCT_W-1:0];
        end
        bce_pkg::OP_EMIT: begin
          out_mv_q  <= avg_q;
          out_pct_q <= pct_q;
        end
        default: ;
      endcase
    end
  end

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= RIDX_LAST && ridx_q <= RIDX_LAST)
    else $error("ring pointer out of range");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == bce_pkg::OP_AVG_INIT) |-> cnt_q <= CNT_W'(RING_DEPTH))
    else $error("nonzero count exceeds ring depth");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex && ctrl_i.op == bce_pkg::OP_EMIT) |=> out_valid_q)
    else $error("emitted result not presented");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex && ctrl_i.op == bce_pkg::OP_EMIT) |-> (!out_valid_q || out_if.ready))
    else $error("result register overwritten while held");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_pct_q <= bce_pkg::PCT_FULL)
    else $error("percent above 100");

endmodule

>>> src/battery_charge_estimator.sv
// Battery charge estimator. Each input transfer carries one converter reading
// (pin millivolts, or a raw 12-bit code when sample_kind is 1) and a read_ok
// flag; it yields exactly one output transfer with the filtered battery
// voltage (mean of the nonzero entries of a RING_DEPTH-deep history, rounded
// to nearest) and a 0..100 percent from a 21-point discharge curve. A small
// microcode program steps a shared datapath: one ring entry per cycle for the
// sum, one quotient bit per cycle from a restoring divider (16 bits at the
// default depth, used twice), and one curve segment per cycle in the search.
// The time from an input transfer until input ready returns depends on the
// path: the voltage at a limit, a history of only zeros, a voltage below the
// table, or interpolation (longest on the lowest segment), plus any time the
// output register is held by backpressure; input ready returns after an idle
// wrap step that follows loading the result into the output register.
// Configuration writes are taken at any time but belong between items. Reset
// clears the history.
module battery_charge_estimator #(
  parameter int RING_DEPTH = bce_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bce_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bce_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  bce_in_if.sink                          in_if,
  bce_out_if.source                       out_if
);

  bce_pkg::bce_ctrl_t  ctrl;
  bce_pkg::bce_flags_t flags;

  bce_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  bce_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .flags_o    (flags),
    .in_if      (in_if),
    .out_if     (out_if)
  );

endmodule

>>> verif/charge_check.sv
module charge_check
  import bce_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bce_in_if                     in_ch,
  bce_out_if                    out_ch,
  output int                    fail_cnt_o,
  output int                    pending_o,
  output int                    checked_o
);

  localparam int HIST_DEPTH = DEFAULT_RING_DEPTH;
  localparam int N_KNOTS    = CURVE_POINTS;

  typedef struct {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
  } charge_t;

  // discharge curve, falling voltage
  int unsigned knot_mv [N_KNOTS] = '{
    4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910, 3870, 3850, 3840,
    3820, 3800, 3790, 3770, 3750, 3730, 3710, 3690, 3610, 3270};
  int unsigned knot_pct [N_KNOTS] = '{
    100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
    45, 40, 35, 30, 25, 20, 15, 10, 5, 0};

  logic                kind_q;
  logic [MV_W-1:0]     full_q;
  logic [MV_W-1:0]     empty_q;
  int unsigned         hist [HIST_DEPTH];
  int unsigned         hist_slot;
  charge_t             charge_q [$];

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
    checked_o  = 0;
  end

  function automatic int unsigned percent_of(input int unsigned v);
    int unsigned dv;
    int unsigned dp;
    int unsigned d;
    int unsigned r;
    if (v >= full_q) return PCT_FULL;
    if (v <= empty_q) return PCT_NONE;
    if (v >= knot_mv[0]) return PCT_FULL;
    for (int k = 0; k < N_KNOTS - 1; k++) begin
      if (v >= knot_mv[k+1]) begin
        dv = knot_mv[k] - knot_mv[k+1];
        dp = knot_pct[k] - knot_pct[k+1];
        d  = knot_mv[k] - v;
        // interpolate, then round half up
        r = (2 * (knot_pct[k] * dv - d * dp) + dv) / (2 * dv);
        return (r > 100) ? 100 : r;
      end
    end
    return PCT_NONE;
  endfunction

  // updates the history, returns the filtered voltage and percent
  function automatic charge_t predict_charge(input logic [SAMPLE_W-1:0] s, input logic ok);
    int unsigned v;
    int unsigned total;
    int unsigned n;
    int unsigned avg;
    charge_t     c;
    if (!ok) v = 0;
    else if (kind_q) v = (int'(s) * RAW_SCALE + RAW_ROUND) >> RAW_SHIFT;
    else v = int'(s) * 2;
    if (v > full_q) v = full_q;
    hist[hist_slot] = v;
    hist_slot = (hist_slot + 1) % HIST_DEPTH;
    total = 0;
    n = 0;
    foreach (hist[i]) begin
      if (hist[i] != 0) begin
        total += hist[i];
        n++;
      end
    end
    avg = (n != 0) ? (total + n / 2) / n : 0;
    c.mv  = avg[MV_W-1:0];
    c.pct = (n != 0) ? PCT_W'(percent_of(c.mv)) : PCT_NONE;
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    charge_t want;
    if (!rst_ni) begin
      kind_q    = 1'b0;
      full_q    = FULL_MV_RST;
      empty_q   = EMPTY_MV_RST;
      hist      = '{default: 0};
      hist_slot = 0;
      charge_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SAMPLE_KIND: kind_q  = cfg_data_i[0];
          CFG_FULL_MV:     full_q  = cfg_data_i[MV_W-1:0];
          CFG_EMPTY_MV:    empty_q = cfg_data_i[MV_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        charge_q.push_back(predict_charge(in_ch.sample, in_ch.read_ok));
      if (out_ch.valid && out_ch.ready) begin
        if (charge_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: mv %0d pct %0d",
                                    out_ch.battery_mv, out_ch.percent));
        end else begin
          want = charge_q.pop_front();
          if (out_ch.battery_mv !== want.mv || out_ch.percent !== want.pct)
            report_mismatch($sformatf("result %0d: mv %0d pct %0d, expected mv %0d pct %0d",
                                      checked_o, out_ch.battery_mv, out_ch.percent,
                                      want.mv, want.pct));
          checked_o++;
        end
      end
      pending_o = charge_q.size();
    end
  end

endmodule

>>> verif/testbench.sv
module testbench;
  import bce_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_STALL    = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bce_in_if  in_ch ();
  bce_out_if out_ch ();

  int  fails;
  int  pending;
  int  checked;
  int  items_sent;
  int  settings_used;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  cur_kind;
  int  cur_full;
  int  cur_empty;
  logic stall_req;

  battery_charge_estimator DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  charge_check u_charge_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_cnt_o (fails),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending);
    $display("Some tests failed");
    $finish;
  end

  // output side: random backpressure plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) hold = LONG_STALL;
      if (hold != 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // called at a clock edge; returns at the edge of the transfer
  task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic ok);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.read_ok <= ok;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic apply_setting(input int kind, input int full, input int empty);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SAMPLE_KIND;
    cfg_data <= CFG_DATA_W'(kind);
    @(posedge clk);
    cfg_idx  <= CFG_FULL_MV;
    cfg_data <= CFG_DATA_W'(full);
    @(posedge clk);
    cfg_idx  <= CFG_EMPTY_MV;
    cfg_data <= CFG_DATA_W'(empty);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_kind  = kind;
    cur_full  = full;
    cur_empty = empty;
    settings_used++;
  endtask

  // converter reading that lands near a battery voltage in the current mode
  function automatic logic [SAMPLE_W-1:0] sample_for_mv(input int mv);
    int code;
    if (cur_kind != 0) code = (mv * 4096 + 3300) / 6600;
    else code = mv / 2;
    if (code > 4095) code = 4095;
    return code[SAMPLE_W-1:0];
  endfunction

  // runs of similar voltages so the history settles, with some noise mixed in
  task automatic run_phase(input int n_items);
    int left;
    int reps;
    int aim;
    int pick;
    left = n_items;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 60) aim = $urandom_range(4300, 3200);
      else if (pick < 75) aim = cur_full + int'($urandom_range(40)) - 20;
      else if (pick < 88) aim = cur_empty + int'($urandom_range(40)) - 20;
      else aim = -1;
      reps = $urandom_range(6, 1);
      repeat (reps) begin
        if (left == 0) break;
        if (aim < 0)
          send_item(SAMPLE_W'($urandom_range(4095)), 1'($urandom_range(1)));
        else
          send_item(sample_for_mv(aim + int'($urandom_range(6))), $urandom_range(99) >= 5);
        left--;
      end
    end
  endtask

  task automatic run_setting(input int kind, input int full, input int empty, input int n);
    drain();
    apply_setting(kind, full, empty);
    run_phase(n);
  endtask

  initial begin
    cfg_we        = 1'b0;
    cfg_idx       = CFG_SAMPLE_KIND;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    in_ch.read_ok = 1'b0;
    stall_req     = 1'b0;
    items_sent    = 0;
    settings_used = 1;
    send_idle_pct = 7;
    recv_idle_pct = 87;
    cur_kind      = 0;
    cur_full      = FULL_MV_RST;
    cur_empty     = EMPTY_MV_RST;
    rst_n         = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty history, failed read, clamp at full
    send_item(12'd0, 1'b1);
    send_item(12'd4095, 1'b0);
    send_item(12'd4095, 1'b1);
    // settle at empty exactly, on the lowest segment, then mid-curve
    repeat (5) send_item(12'd1500, 1'b1);
    repeat (5) send_item(12'd1700, 1'b1);
    repeat (5) send_item(12'd1900, 1'b1);
    send_item(12'd1, 1'b1);
    // raw codes, full raised above the top of the table
    drain();
    apply_setting(1, 8191, 0);
    send_item(12'd4095, 1'b1);
    send_item(12'd0, 1'b1);
    send_item(12'd4095, 1'b1);

    run_setting(0, FULL_MV_RST, EMPTY_MV_RST, 40);
    // output held off long enough for the input to back up
    stall_req <= 1'b1;
    @(posedge clk);
    stall_req <= 1'b0;
    run_phase(30);
    drain();
    run_phase(60);
    run_setting(1, FULL_MV_RST, EMPTY_MV_RST, 130);
    run_setting(1, 8191, 0, 120);

    send_idle_pct = 87;
    recv_idle_pct = 7;
    run_setting(0, 0, 8191, 60);
    run_setting(0, 3800, 3700, 120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_setting(1, FULL_MV_RST, 8191, 100);
    run_setting(0, $urandom_range(4500, 3300), $urandom_range(3900, 2800), 130);
    run_setting(0, 8191, 8191, 80);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d samples over %0d register settings, both sample kinds,",
             items_sent, settings_used);
    $display("a %0d-cycle output hold-off and %0d compared results.", LONG_STALL, checked);
    if (fails == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
src/bce_pkg.sv
src/bce_if.sv
src/bce_seq.sv
src/bce_dp.sv
src/battery_charge_estimator.sv
verif/charge_check.sv
verif/testbench.sv
